// ----- sv/oll_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package oll_pkg;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_DUMP   = 2'd3;

    localparam int OUT_BITS   = 32;
    localparam int COUNT_BITS = 5;

    typedef struct packed {
        logic [1:0] op;
        logic       backward;
    } t_cmd_ctl;

    typedef struct packed {
        logic                  found;
        logic                  has_prev;
        logic [OUT_BITS-1:0]   prev_value;
        logic                  has_next;
        logic [OUT_BITS-1:0]   next_value;
        logic [OUT_BITS-1:0]   item_value;
        logic                  empty_res;
        logic                  full_res;
        logic                  last;
        logic [COUNT_BITS-1:0] entry_count;
    } t_res;

endpackage

`default_nettype wire

// ----- sv/oll_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module oll_front #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [1:0]             i_op,
    input  wire logic signed [31:0]     i_value,
    input  wire logic                   i_backward,
    output logic                        o_q_vld,
    output oll_pkg::t_cmd_ctl           o_q_ctl,
    output logic [VALUE_BITS-1:0]       o_q_val,
    input  wire logic                   i_q_deq
);

    localparam int WB = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam int DW = VALUE_BITS + 3;

    logic [DW-1:0] r_ent [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic [DW-1:0] n_word;
    logic          w_acc;
    logic [DW-1:0] w_head;

    // value held in its low VALUE_BITS bits, zero-extended beyond 32
    assign n_word = {VALUE_BITS'(WB'($unsigned(i_value))), i_op, i_backward};
    assign full   = (r_cnt == 2'd2);
    assign w_acc  = push && !full;

    assign w_head  = r_ent[r_rp];
    assign o_q_vld = (r_cnt != 2'd0);
    assign o_q_val = w_head[DW-1:3];
    assign o_q_ctl = oll_pkg::t_cmd_ctl'(w_head[2:0]);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ent[r_wp] <= n_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) begin
                r_wp <= !r_wp;
            end
            if (i_q_deq) begin
                r_rp <= !r_rp;
            end
            if (w_acc && !i_q_deq) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!w_acc && i_q_deq) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    a_no_deq_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_deq |-> (r_cnt != 2'd0))
        else $error("command queue read while empty");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("command queue count overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd1) |-> (r_wp != r_rp))
        else $error("command queue pointers out of step");

endmodule

`default_nettype wire

// ----- sv/oll_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module oll_back #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_q_vld,
    input  wire oll_pkg::t_cmd_ctl      i_q_ctl,
    input  wire logic [VALUE_BITS-1:0]  i_q_val,
    output logic                        o_q_deq,
    output logic                        o_res_vld,
    output oll_pkg::t_res               o_res,
    input  wire logic                   i_pop
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WB = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    logic [VALUE_BITS-1:0] r_cell [CAPACITY];
    logic [CAPACITY-1:0]   r_vld, n_vld;
    logic [CW-1:0]         r_len, n_len;
    logic [1:0]            r_state, n_state;
    oll_pkg::t_cmd_ctl     r_ctl;
    logic [VALUE_BITS-1:0] r_val;
    logic [CAPACITY-1:0]   r_first, r_sel, n_sel;
    oll_pkg::t_res         r_res, n_res;
    logic                  r_ovld;

    logic [CAPACITY-1:0]   w_hit, w_first, w_prev_oh, w_next_oh, w_free_oh, w_ge, w_tail_oh;
    logic [VALUE_BITS-1:0] w_prev_v, w_next_v, w_item_v;
    logic                  w_found, w_free, w_emit, w_app, w_del, w_last;

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit[i] = r_vld[i] && (r_cell[i] == i_q_val);
        end
    end

    // isolate the lowest set bit: first match from the head
    assign w_first   = w_hit & (~w_hit + CAPACITY'(1));
    assign w_prev_oh = r_first >> 1;
    assign w_next_oh = (r_first << 1) & r_vld;
    assign w_free_oh = ~r_vld & {r_vld[CAPACITY-2:0], 1'b1};
    assign w_ge      = ~(r_first - CAPACITY'(1));
    assign w_tail_oh = r_vld & ~(r_vld >> 1);
    assign w_found   = |r_first;
    assign w_free    = !r_ovld || i_pop;

    always_comb begin
        w_prev_v = '0;
        w_next_v = '0;
        w_item_v = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_prev_v = w_prev_v | (r_cell[i] & {VALUE_BITS{w_prev_oh[i]}});
            w_next_v = w_next_v | (r_cell[i] & {VALUE_BITS{w_next_oh[i]}});
            w_item_v = w_item_v | (r_cell[i] & {VALUE_BITS{r_sel[i]}});
        end
    end

    assign w_last = r_ctl.backward ? r_sel[0] : (((r_sel << 1) & r_vld) == '0);

    always_comb begin
        n_state = r_state;
        n_vld   = r_vld;
        n_len   = r_len;
        n_sel   = r_sel;
        n_res   = '0;
        n_res.entry_count = oll_pkg::COUNT_BITS'(r_len);
        w_emit  = 1'b0;
        w_app   = 1'b0;
        w_del   = 1'b0;
        o_q_deq = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    o_q_deq = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_free) begin
                    n_state    = S_IDLE;
                    n_res.last = 1'b1;
                    case (r_ctl.op)
                        oll_pkg::OP_APPEND: begin
                            w_emit = 1'b1;
                            if (r_vld[CAPACITY-1]) begin
                                n_res.full_res = 1'b1;
                            end else begin
                                w_app = 1'b1;
                                n_vld = {r_vld[CAPACITY-2:0], 1'b1};
                                n_len = r_len + CW'(1);
                                n_res.entry_count = oll_pkg::COUNT_BITS'(n_len);
                            end
                        end
                        oll_pkg::OP_SEARCH: begin
                            w_emit           = 1'b1;
                            n_res.found      = w_found;
                            n_res.has_prev   = w_found && !r_first[0];
                            n_res.prev_value = 32'(WB'(w_prev_v));
                            n_res.has_next   = |w_next_oh;
                            n_res.next_value = 32'(WB'(w_next_v));
                        end
                        oll_pkg::OP_DELETE: begin
                            w_emit      = 1'b1;
                            n_res.found = w_found;
                            if (w_found) begin
                                w_del = 1'b1;
                                n_vld = r_vld >> 1;
                                n_len = r_len - CW'(1);
                                n_res.entry_count = oll_pkg::COUNT_BITS'(n_len);
                            end
                        end
                        default: begin
                            if (r_len == '0) begin
                                w_emit          = 1'b1;
                                n_res.empty_res = 1'b1;
                            end else begin
                                n_sel   = r_ctl.backward ? w_tail_oh : CAPACITY'(1);
                                n_state = S_DUMP;
                            end
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_free) begin
                    w_emit           = 1'b1;
                    n_res.item_value = 32'(WB'(w_item_v));
                    n_res.last       = w_last;
                    n_sel = r_ctl.backward ? (r_sel >> 1) : (r_sel << 1);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // cells: append writes the first free slot, delete pulls later entries down
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g < CAPACITY - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (w_app && w_free_oh[g]) begin
                    r_cell[g] <= r_val;
                end else if (w_del && w_ge[g]) begin
                    r_cell[g] <= r_cell[g+1];
                end
            end
        end else begin : g_end
            always_ff @(posedge i_clk) begin
                if (w_app && w_free_oh[g]) begin
                    r_cell[g] <= r_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel <= n_sel;
        if (o_q_deq) begin
            r_ctl   <= i_q_ctl;
            r_val   <= i_q_val;
            r_first <= w_first;
        end
        if (w_emit) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= '0;
            r_len   <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_len   <= n_len;
            if (w_emit) begin
                r_ovld <= 1'b1;
            end else if (i_pop) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_res_vld = r_ovld;
    assign o_res     = r_res;

    a_thermo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld & ~{r_vld[CAPACITY-2:0], 1'b1}) == '0)
        else $error("occupied cells not packed from the head");

    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_vld) == int'(r_len))
        else $error("length disagrees with occupied cells");

    a_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> ($onehot0(r_first) && ((r_first & ~r_vld) == '0)))
        else $error("match select not a single occupied cell");

    a_dump_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> $onehot(r_sel & r_vld))
        else $error("dump pointer off the list");

    a_no_clobber: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !i_pop) |=> $stable(r_res))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

// ----- sv/ordered_list_append_search_delete.sv -----
// Ordered list of up to CAPACITY values with append, search, delete and dump.
// Input side is a queue: drive push with op/value/backward; the word is taken
// on a clock edge where push is high and full is low. A two-word command
// queue sits in front, so new words are taken while the list is busy.
// Result side is a queue: while empty is low the oldest result is on the
// o_ ports; it is taken on an edge where pop is high. Holding pop low stalls
// the list; commands keep queueing until full rises.
// Every word gives one result, except a dump of a non-empty list, which
// gives one result per entry with o_last on the final one.
// Steps: append, search and delete pass through IDLE, which takes the word
// and compares every cell against the value, and EXEC, which acts; a dump of
// a non-empty list goes on to DUMP, which emits its entries in turn. Each
// result is registered before it reaches the o_ ports.
// Reset (synchronous, i_rst_n low) empties the list and both queues; cell
// contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_append_search_delete #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         i_op,
    input  wire logic signed [31:0] i_value,
    input  wire logic               i_backward,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    o_found,
    output logic                    o_has_prev,
    output logic signed [31:0]      o_prev_value,
    output logic                    o_has_next,
    output logic signed [31:0]      o_next_value,
    output logic signed [31:0]      o_item_value,
    output logic                    o_empty_res,
    output logic                    o_full_res,
    output logic                    o_last,
    output logic [4:0]              o_entry_count
);

    logic                  w_q_vld, w_q_deq, w_res_vld;
    oll_pkg::t_cmd_ctl     w_q_ctl;
    logic [VALUE_BITS-1:0] w_q_val;
    oll_pkg::t_res         w_res;

    oll_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_backward (i_backward),
        .o_q_vld    (w_q_vld),
        .o_q_ctl    (w_q_ctl),
        .o_q_val    (w_q_val),
        .i_q_deq    (w_q_deq)
    );

    oll_back #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_vld   (w_q_vld),
        .i_q_ctl   (w_q_ctl),
        .i_q_val   (w_q_val),
        .o_q_deq   (w_q_deq),
        .o_res_vld (w_res_vld),
        .o_res     (w_res),
        .i_pop     (pop && w_res_vld)
    );

    assign empty         = !w_res_vld;
    assign o_found       = w_res.found;
    assign o_has_prev    = w_res.has_prev;
    assign o_prev_value  = $signed(w_res.prev_value);
    assign o_has_next    = w_res.has_next;
    assign o_next_value  = $signed(w_res.next_value);
    assign o_item_value  = $signed(w_res.item_value);
    assign o_empty_res   = w_res.empty_res;
    assign o_full_res    = w_res.full_res;
    assign o_last        = w_res.last;
    assign o_entry_count = w_res.entry_count;

endmodule

`default_nettype wire
